>>> hdl/jda_pkg.sv
// ----------------------------------------------------------------------------
// jda_pkg
// Shared types, register codes, reset values and the arctangent table for
// the joystick direction block.
// ----------------------------------------------------------------------------
`default_nettype none

package jda_pkg;

  // Configuration port geometry
  localparam int CFG_BITS    = 10;
  localparam int INDEX_BITS  = 2;
  localparam int MARGIN_BITS = 9;
  localparam int REST_BITS   = 10;

  // Result widths
  localparam int DIR_BITS    = 9;

  // Register indexes on the configuration port
  typedef enum logic [INDEX_BITS-1:0] {
    REG_DRIFT_MARGIN    = 2'd0,
    REG_VERTICAL_REST   = 2'd1,
    REG_HORIZONTAL_REST = 2'd2,
    REG_AXIS_BIAS       = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET     = 9'd25;
  localparam logic [REST_BITS-1:0]   VERT_REST_RESET  = 10'd496;
  localparam logic [REST_BITS-1:0]   HORIZ_REST_RESET = 10'd509;
  localparam logic [REST_BITS-1:0]   BIAS_RESET       = 10'd512;

  // Fixed-point CORDIC
  localparam int PRE_SHIFT  = 20;
  localparam int TABLE_LEN  = 24;
  localparam int STEP_BITS  = $clog2(TABLE_LEN);
  localparam int ATAN_BITS  = 14;
  localparam int ANGLE_BITS = 19;   // signed degrees, 8 fractional bits

  localparam logic signed [ANGLE_BITS-1:0] DEG90  = 19'sd23040;
  localparam logic signed [ANGLE_BITS-1:0] DEG180 = 19'sd46080;
  localparam logic signed [ANGLE_BITS-1:0] DEG360 = 19'sd92160;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_ITER = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // atan(2^-i) in degrees, 8 fractional bits, rounded to nearest
  function automatic logic [ATAN_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] idx);
    logic [ATAN_BITS-1:0] val;
    case (idx)
      5'd0:    val = 14'd11520;
      5'd1:    val = 14'd6801;
      5'd2:    val = 14'd3593;
      5'd3:    val = 14'd1824;
      5'd4:    val = 14'd916;
      5'd5:    val = 14'd458;
      5'd6:    val = 14'd229;
      5'd7:    val = 14'd115;
      5'd8:    val = 14'd57;
      5'd9:    val = 14'd29;
      5'd10:   val = 14'd14;
      5'd11:   val = 14'd7;
      5'd12:   val = 14'd4;
      5'd13:   val = 14'd2;
      5'd14:   val = 14'd1;
      default: val = 14'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

>>> hdl/jda_channels.sv
// ----------------------------------------------------------------------------
// jda_channels
// Valid/ready channels for the joystick sample pair and the direction result.
// ----------------------------------------------------------------------------
`default_nettype none

interface jda_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] vertical_sample;
  logic [SAMPLE_BITS-1:0] horizontal_sample;

  modport source (output valid, output vertical_sample, output horizontal_sample,
                  input ready);
  modport sink   (input valid, input vertical_sample, input horizontal_sample,
                  output ready);
endinterface

interface jda_direction_if;
  logic                          valid;
  logic                          ready;
  logic [jda_pkg::DIR_BITS-1:0]  direction_degrees;
  logic                          in_dead_zone;

  modport source (output valid, output direction_degrees, output in_dead_zone,
                  input ready);
  modport sink   (input valid, input direction_degrees, input in_dead_zone,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/joystick_direction_angle_top.sv
// A SAMPLE request taken in the idle state passes the set-up state, the rotation state
//   (once per rotation) and the result state, which waits for a free output register.
// New requests wait until the last one leaves the result state, as the single shared
//   add/shift CORDIC stage serves every rotation.
// Dead zone and on-axis requests skip the rotations.
// Reset (rst, synchronous): config registers return to their defaults, held angle 0.
// ----------------------------------------------------------------------------
// joystick_direction_angle_top
// Joystick direction in whole degrees (0..360) from a pair of axis samples,
// with a rest dead zone that repeats the last direction.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_direction_angle_top #(
  parameter int SAMPLE_BITS  = 10,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [jda_pkg::INDEX_BITS-1:0]  cfg_index,
  input  wire logic [jda_pkg::CFG_BITS-1:0]    cfg_data,
  jda_sample_if.sink                           samples,
  jda_direction_if.source                      direction
);

  // Signed width that holds a sample, a rest value and their difference
  localparam int AXIS_BITS = ((SAMPLE_BITS > jda_pkg::REST_BITS) ?
                              SAMPLE_BITS : jda_pkg::REST_BITS) + 1;
  // CORDIC datapath: scaled axis plus headroom for gain (about 1.65 * sqrt 2)
  localparam int WIDE_BITS = AXIS_BITS + jda_pkg::PRE_SHIFT + 2;
  localparam int NSTEPS    = (CORDIC_STEPS < jda_pkg::TABLE_LEN) ?
                             CORDIC_STEPS : jda_pkg::TABLE_LEN;
  localparam logic [jda_pkg::STEP_BITS-1:0] LAST_STEP = jda_pkg::STEP_BITS'(NSTEPS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [jda_pkg::MARGIN_BITS-1:0] drift_margin;
  logic [jda_pkg::REST_BITS-1:0]   vertical_rest;
  logic [jda_pkg::REST_BITS-1:0]   horizontal_rest;
  logic [jda_pkg::REST_BITS-1:0]   axis_bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_margin    <= jda_pkg::MARGIN_RESET;
      vertical_rest   <= jda_pkg::VERT_REST_RESET;
      horizontal_rest <= jda_pkg::HORIZ_REST_RESET;
      axis_bias       <= jda_pkg::BIAS_RESET;
    end else if (cfg_we) begin
      case (jda_pkg::cfg_reg_t'(cfg_index))
        jda_pkg::REG_DRIFT_MARGIN: begin
          drift_margin <= cfg_data[jda_pkg::MARGIN_BITS-1:0];
        end
        jda_pkg::REG_VERTICAL_REST: begin
          vertical_rest <= cfg_data[jda_pkg::REST_BITS-1:0];
        end
        jda_pkg::REG_HORIZONTAL_REST: begin
          horizontal_rest <= cfg_data[jda_pkg::REST_BITS-1:0];
        end
        jda_pkg::REG_AXIS_BIAS: begin
          axis_bias <= cfg_data[jda_pkg::REST_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  jda_pkg::state_t                         state;
  logic [SAMPLE_BITS-1:0]                  v_smp;
  logic [SAMPLE_BITS-1:0]                  h_smp;
  logic signed [WIDE_BITS-1:0]             x_acc;
  logic signed [WIDE_BITS-1:0]             y_acc;
  logic signed [jda_pkg::ANGLE_BITS-1:0]   z_acc;
  logic [jda_pkg::STEP_BITS-1:0]           step;
  logic                                    dead;
  logic [jda_pkg::DIR_BITS-1:0]            held_direction;

  logic                                    out_valid;
  logic [jda_pkg::DIR_BITS-1:0]            out_dir;
  logic                                    out_dead;

  // --------------------------------------------------------------------------
  // Set-up: dead zone test, bias removal, scaling
  // --------------------------------------------------------------------------
  logic signed [AXIS_BITS-1:0] v_s, h_s, vr_s, hr_s, bias_s, margin_s;
  logic signed [AXIS_BITS-1:0] v_dev, h_dev, v_mag, h_mag;
  logic signed [AXIS_BITS-1:0] y_off, x_off;
  logic signed [WIDE_BITS-1:0] x_w, y_w;
  logic                        dead_zone;

  assign v_s      = $signed({1'b0, (AXIS_BITS-1)'(v_smp)});
  assign h_s      = $signed({1'b0, (AXIS_BITS-1)'(h_smp)});
  assign vr_s     = $signed({1'b0, (AXIS_BITS-1)'(vertical_rest)});
  assign hr_s     = $signed({1'b0, (AXIS_BITS-1)'(horizontal_rest)});
  assign bias_s   = $signed({1'b0, (AXIS_BITS-1)'(axis_bias)});
  assign margin_s = $signed({1'b0, (AXIS_BITS-1)'(drift_margin)});

  assign v_dev = v_s - vr_s;
  assign h_dev = h_s - hr_s;
  assign v_mag = v_dev[AXIS_BITS-1] ? -v_dev : v_dev;
  assign h_mag = h_dev[AXIS_BITS-1] ? -h_dev : h_dev;
  // Inclusive on both axes
  assign dead_zone = (v_mag <= margin_s) && (h_mag <= margin_s);

  assign y_off = v_s - bias_s;
  assign x_off = h_s - bias_s;
  // Scale up by 2^PRE_SHIFT, sign-extended into the headroom
  assign x_w = {{(WIDE_BITS-AXIS_BITS-jda_pkg::PRE_SHIFT){x_off[AXIS_BITS-1]}},
                x_off, {jda_pkg::PRE_SHIFT{1'b0}}};
  assign y_w = {{(WIDE_BITS-AXIS_BITS-jda_pkg::PRE_SHIFT){y_off[AXIS_BITS-1]}},
                y_off, {jda_pkg::PRE_SHIFT{1'b0}}};

  // --------------------------------------------------------------------------
  // Shared CORDIC stage: one arithmetic shift pair and three adders
  // --------------------------------------------------------------------------
  logic signed [WIDE_BITS-1:0]           xs, ys;
  logic signed [jda_pkg::ANGLE_BITS-1:0] atan_s;

  // Arithmetic shift floors toward minus infinity
  assign xs     = x_acc >>> step;
  assign ys     = y_acc >>> step;
  assign atan_s = $signed({{(jda_pkg::ANGLE_BITS-jda_pkg::ATAN_BITS){1'b0}},
                           jda_pkg::atan_entry(step)});

  // --------------------------------------------------------------------------
  // Result: offset by 180, clamp, floor to whole degrees
  // --------------------------------------------------------------------------
  logic signed [jda_pkg::ANGLE_BITS-1:0] z_sum, z_clamp;
  logic [jda_pkg::DIR_BITS-1:0]          dir_calc;
  logic                                  out_free;

  assign z_sum   = z_acc + jda_pkg::DEG180;
  assign z_clamp = z_sum[jda_pkg::ANGLE_BITS-1] ? '0 :
                   (z_sum > jda_pkg::DEG360) ? jda_pkg::DEG360 : z_sum;
  assign dir_calc = z_clamp[jda_pkg::DIR_BITS+7:8];

  // The result register frees when empty or when its content is taken now
  assign out_free = !out_valid || direction.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= jda_pkg::ST_IDLE;
      held_direction <= '0;
      out_valid      <= 1'b0;
    end else begin
      case (state)
        jda_pkg::ST_IDLE: begin
          // Capture the request
          if (samples.valid) begin
            state <= jda_pkg::ST_PREP;
          end
        end
        jda_pkg::ST_PREP: begin
          if (dead_zone) begin
            state <= jda_pkg::ST_DONE;
          end else if (y_off == '0 || x_off == '0) begin
            // On an axis, or the origin: exact angle, no rotations
            state <= jda_pkg::ST_DONE;
          end else begin
            state <= jda_pkg::ST_ITER;
          end
        end
        jda_pkg::ST_ITER: begin
          if (step == LAST_STEP) begin
            state <= jda_pkg::ST_DONE;
          end
        end
        jda_pkg::ST_DONE: begin
          // Hold until the result register can take the new direction
          if (out_free) begin
            if (!dead) begin
              held_direction <= dir_calc;
            end
            state <= jda_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= jda_pkg::ST_IDLE;
        end
      endcase
      // Raise valid as a new direction lands, drop it once taken
      if (state == jda_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (direction.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    case (state)
      jda_pkg::ST_IDLE: begin
        if (samples.valid) begin
          v_smp <= samples.vertical_sample;
          h_smp <= samples.horizontal_sample;
        end
      end
      jda_pkg::ST_PREP: begin
        dead <= dead_zone;
        step <= '0;
        if (y_off == '0) begin
          z_acc <= x_off[AXIS_BITS-1] ? jda_pkg::DEG180 : '0;
        end else if (x_off == '0) begin
          z_acc <= y_off[AXIS_BITS-1] ? -jda_pkg::DEG90 : jda_pkg::DEG90;
        end else if (x_off[AXIS_BITS-1] && !y_off[AXIS_BITS-1]) begin
          // Rotate by -90 into the right half plane
          x_acc <= y_w;
          y_acc <= -x_w;
          z_acc <= jda_pkg::DEG90;
        end else if (x_off[AXIS_BITS-1]) begin
          // Rotate by +90 into the right half plane
          x_acc <= -y_w;
          y_acc <= x_w;
          z_acc <= -jda_pkg::DEG90;
        end else begin
          x_acc <= x_w;
          y_acc <= y_w;
          z_acc <= '0;
        end
      end
      jda_pkg::ST_ITER: begin
        // Drive y toward zero, accumulate the angle turned
        if (!y_acc[WIDE_BITS-1]) begin
          x_acc <= x_acc + ys;
          y_acc <= y_acc - xs;
          z_acc <= z_acc + atan_s;
        end else begin
          x_acc <= x_acc - ys;
          y_acc <= y_acc + xs;
          z_acc <= z_acc - atan_s;
        end
        step <= step + 1'b1;
      end
      jda_pkg::ST_DONE: begin
        if (out_free) begin
          out_dir  <= dead ? held_direction : dir_calc;
          out_dead <= dead;
        end
      end
      default: begin
      end
    endcase
  end

  assign samples.ready               = (state == jda_pkg::ST_IDLE);
  assign direction.valid             = out_valid;
  assign direction.direction_degrees = out_dir;
  assign direction.in_dead_zone      = out_dead;

endmodule

`default_nettype wire
